@@ src/jftd_pkg.sv @@
`timescale 1ns / 1ps
package jftd_pkg;

    localparam int unsigned VW = 21;
    localparam int unsigned DW = 8;
    localparam logic [6:0] POWERUP_MARK = 7'h5A;
    localparam logic [VW-1:0] DEVIATION_LIMIT = 21'd2000;

    localparam logic [2:0] ST_NORMAL   = 3'd0;
    localparam logic [2:0] ST_HOLD     = 3'd1;
    localparam logic [2:0] ST_JWAIT    = 3'd2;
    localparam logic [2:0] ST_LOST     = 3'd3;
    localparam logic [2:0] ST_DEV      = 3'd4;
    localparam logic [2:0] ST_DEV_LOST = 3'd5;
    localparam logic [2:0] ST_OTHER    = 3'd6;
    localparam logic [2:0] ST_BAD      = 3'd7;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;
    localparam logic [1:0] MODE_TREND  = 2'd3;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MODE      = 3'd1;
    localparam logic [2:0] REG_WAIT      = 3'd2;
    localparam logic [2:0] REG_STEP      = 3'd3;
    localparam logic [2:0] REG_TREND     = 3'd4;
    localparam logic [2:0] REG_DAMPING   = 3'd5;

    typedef struct packed {
        logic [VW-1:0] av;
        logic [VW-1:0] fill_val;
        logic          fill;
        logic [2:0]    st;
        logic          flag;
        logic [DW-1:0] d;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FILL,
        B_SCAN,
        B_HEAD,
        B_TAIL,
        B_DIV,
        B_OUT
    } t_bstate;

endpackage

@@ src/jftd_ifs.sv @@
`timescale 1ns / 1ps
interface jftd_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] distance;
    logic [20:0] present_value;
    logic [2:0]  status_in;
    modport source (output valid, output distance, output present_value, output status_in,
                    input ready);
    modport sink (input valid, input distance, input present_value, input status_in,
                  output ready);
endinterface

interface jftd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] damped_distance;
    logic [2:0]  status_out;
    logic        jump_accepted;
    modport source (output valid, output damped_distance, output status_out,
                    output jump_accepted, input ready);
    modport sink (input valid, input damped_distance, input status_out,
                  input jump_accepted, output ready);
endinterface

@@ src/jftd_front.sv @@
`timescale 1ns / 1ps
module jftd_front import jftd_pkg::*; #(
    parameter int HISTORY_DEPTH = 64,
    parameter int CONFIRM_COUNT = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [20:0]  i_cfg_data,
    jftd_in_if.sink      i_in_ch,
    input  logic         i_q_full,
    output logic         o_push,
    output t_job         o_job
);
    localparam logic [DW-1:0] DMAX = DW'(HISTORY_DEPTH - 1);
    localparam logic [6:0] CC = 7'(CONFIRM_COUNT);

    logic [20:0] r_thr, r_step, r_trend;
    logic [1:0]  r_mode;
    logic [15:0] r_wtime;
    logic [5:0]  r_damp;

    logic [20:0] r_acc, n_acc;
    logic [6:0]  r_conf, n_conf;
    logic [15:0] r_wait, n_wait;

    logic [20:0] meas, pv, diff, diff2, step, a_val, pvms;
    logic [21:0] pvps;
    logic [2:0]  st;
    logic [6:0]  c1;
    logic        flag, fill;
    logic [DW-1:0] dext;

    assign meas = i_in_ch.distance;
    assign pv = i_in_ch.present_value;
    assign i_in_ch.ready = !i_q_full;
    assign o_push = i_in_ch.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= 21'd5000;
            r_mode  <= MODE_DIRECT;
            r_wtime <= 16'd10;
            r_step  <= 21'd1000;
            r_trend <= 21'd0;
            r_damp  <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_thr <= i_cfg_data;
                REG_MODE:      r_mode <= i_cfg_data[1:0];
                REG_WAIT:      r_wtime <= i_cfg_data[15:0];
                REG_STEP:      r_step <= i_cfg_data;
                REG_TREND:     r_trend <= i_cfg_data;
                REG_DAMPING:   r_damp <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // step toward the new distance
    always_comb begin
        step = (r_mode == MODE_FIXED) ? r_step : r_trend;
        pvms = pv - step;
        pvps = {1'b0, pv} + {1'b0, step};
        if (meas < pv) begin
            a_val = (pv <= step || pvms < meas) ? meas : pvms;
        end else begin
            a_val = (pvps > {1'b0, meas}) ? meas : pvps[20:0];
        end
    end

    always_comb begin
        st = (i_in_ch.status_in == ST_BAD) ? ST_OTHER : i_in_ch.status_in;
        flag = 1'b0;
        fill = 1'b0;
        n_acc = r_acc;
        n_conf = r_conf;
        n_wait = r_wait;
        c1 = r_conf + 7'd1;
        diff = (meas > pv) ? meas - pv : pv - meas;
        if (diff < r_thr) begin
            n_acc = meas;
            if (r_conf != POWERUP_MARK) n_conf = 7'd0;
            n_wait = 16'd0;
        end else begin
            fill = (r_conf == POWERUP_MARK);
            if (c1 < CC) begin
                n_conf = c1;
                n_wait = r_wtime;
            end else begin
                n_conf = CC;
                unique case (r_mode)
                    MODE_DIRECT: n_acc = meas;
                    MODE_WAIT: begin
                        if (r_wait == 16'd0) begin
                            n_acc = meas;
                            flag = 1'b1;
                        end else if (st != ST_HOLD) begin
                            n_wait = r_wait - 16'd1;
                            st = ST_JWAIT;
                            n_acc = pv;
                        end
                    end
                    default: n_acc = a_val;
                endcase
            end
        end
        diff2 = (n_acc > pv) ? n_acc - pv : pv - n_acc;
        if (diff2 >= DEVIATION_LIMIT) begin
            if (st == ST_NORMAL) st = ST_DEV;
            else if (st == ST_LOST) st = ST_DEV_LOST;
        end
        dext = DW'(r_damp);
        if (dext > DMAX) dext = DMAX;
    end

    assign o_job = '{av: n_acc, fill_val: meas, fill: fill, st: st, flag: flag, d: dext};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_conf <= POWERUP_MARK;
            r_wait <= '0;
        end else if (o_push) begin
            r_acc  <= n_acc;
            r_conf <= n_conf;
            r_wait <= n_wait;
        end
    end
endmodule

@@ src/jftd_queue.sv @@
`timescale 1ns / 1ps
module jftd_queue import jftd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);
    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

@@ src/jftd_back.sv @@
`timescale 1ns / 1ps
module jftd_back import jftd_pkg::*; #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_job,
    output logic        o_pop,
    jftd_out_if.source  o_out_ch
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SW = VW + AW + 1;
    localparam int CW = $clog2(SW + 1);
    localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [VW-1:0] mem [HISTORY_DEPTH];
    logic [VW-1:0] r_q;
    logic [AW-1:0] r_ptr, r_didx, dd;
    logic          r_issue, r_dv;
    logic [SW-1:0] r_tot, r_num;
    logic [VW-1:0] r_mn, r_mx;
    logic [AW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [AW:0]   rs, rsub;
    logic          ge, load_out;
    logic [VW-1:0] r_res;
    logic [2:0]    r_st;
    logic          r_flag, r_ov;

    assign dd = r_job.d[AW-1:0];
    assign rs = {r_rem, r_num[SW-1]};
    assign ge = rs >= {1'b0, dd};
    assign rsub = rs - {1'b0, dd};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_q_valid) n_state = i_job.fill ? B_FILL : B_SCAN;
            B_FILL: if (r_ptr == LAST) n_state = B_SCAN;
            B_SCAN: if (r_dv && r_didx == '0) n_state = B_HEAD;
            B_HEAD: n_state = (dd == LAST) ? B_DIV : B_TAIL;
            B_TAIL: if (r_ptr == LAST) n_state = B_DIV;
            B_DIV:  if (dd == '0 || r_cnt == CW'(SW - 1)) n_state = B_OUT;
            B_OUT:  if (!r_ov || o_out_ch.ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        we = 1'b0;
        waddr = r_ptr;
        wdata = r_job.av;
        load_out = 1'b0;
        unique case (r_state)
            B_IDLE: o_pop = i_q_valid;
            B_FILL: begin
                we = 1'b1;
                wdata = r_job.fill_val;
            end
            B_SCAN: begin
                we = r_dv && (r_didx < dd);
                waddr = r_didx + AW'(1);
                wdata = r_q;
            end
            B_HEAD: begin
                we = 1'b1;
                waddr = '0;
            end
            B_TAIL: we = 1'b1;
            B_OUT:  load_out = !r_ov || o_out_ch.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_q <= mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_job   <= i_job;
                r_ptr   <= i_job.fill ? '0 : i_job.d[AW-1:0];
                r_issue <= 1'b1;
                r_dv    <= 1'b0;
                r_tot   <= SW'(i_job.av);
                r_mn    <= i_job.av;
                r_mx    <= i_job.av;
            end
            B_FILL: r_ptr <= (r_ptr == LAST) ? dd : r_ptr + AW'(1);
            B_SCAN: begin
                r_dv   <= r_issue;
                r_didx <= r_ptr;
                if (r_issue) begin
                    if (r_ptr == '0) r_issue <= 1'b0;
                    else r_ptr <= r_ptr - AW'(1);
                end
                if (r_dv) begin
                    r_tot <= r_tot + SW'(r_q);
                    if (r_didx < dd) begin
                        if (r_q < r_mn) r_mn <= r_q;
                        if (r_q > r_mx) r_mx <= r_q;
                    end
                end
            end
            B_HEAD: begin
                r_ptr <= dd + AW'(1);
                r_num <= r_tot - SW'(r_mn) - SW'(r_mx) + SW'(dd[AW-1:1]);
                r_rem <= '0;
                r_cnt <= '0;
            end
            B_TAIL: r_ptr <= r_ptr + AW'(1);
            B_DIV: begin
                r_rem <= ge ? rsub[AW-1:0] : rs[AW-1:0];
                r_num <= {r_num[SW-2:0], ge};
                r_cnt <= r_cnt + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res  <= (dd == '0) ? r_job.av : r_num[VW-1:0];
            r_st   <= r_job.st;
            r_flag <= r_job.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_ch.valid = r_ov;
    assign o_out_ch.damped_distance = r_res;
    assign o_out_ch.status_out = r_st;
    assign o_out_ch.jump_accepted = r_flag;
endmodule

@@ src/jump_filter_trimmed_damping.sv @@
`timescale 1ns / 1ps
// channel   dir  payload                                        handshake
// i_in_ch   in   distance, present_value, status_in             valid/ready
// o_out_ch  out  damped_distance, status_out, jump_accepted     valid/ready
// cfg       in   i_cfg_idx, i_cfg_data                          i_cfg_we
//
// one result per item; the back end takes a new item only once the last one's result
// is loaded into the output register, after the history walk and the 28-step
// bit-serial divider (28 steps at depth 64; cut short when damping is off)
// the first jump after reset first fills the whole history with its distance
// a two-entry queue lets the front take items while the back end works
// synchronous active-low reset; history memory is not cleared
module jump_filter_trimmed_damping import jftd_pkg::*; #(
    parameter int HISTORY_DEPTH = 64,
    parameter int CONFIRM_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    jftd_in_if.sink     i_in_ch,
    jftd_out_if.source  o_out_ch
);
    logic q_full, push, pop, q_valid;
    t_job job_in, job_out;

    jftd_front #(.HISTORY_DEPTH(HISTORY_DEPTH), .CONFIRM_COUNT(CONFIRM_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_ch(i_in_ch), .i_q_full(q_full), .o_push(push), .o_job(job_in)
    );

    jftd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in),
        .i_pop(pop), .o_full(q_full), .o_valid(q_valid), .o_job(job_out)
    );

    jftd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_job(job_out),
        .o_pop(pop), .o_out_ch(o_out_ch)
    );
endmodule

@@ src/jftd_checker.sv @@
`timescale 1ns / 1ps
module jftd_checker import jftd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_out_dist,
    input logic [2:0]  i_out_st,
    input logic        i_out_flag
);
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_dist)
        && $stable(i_out_st) && $stable(i_out_flag))
        else $error("stalled result changed");
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_st != ST_BAD)
        else $error("bad status code");
endmodule

bind jump_filter_trimmed_damping jftd_checker u_jftd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in_ch.ready),
    .i_out_valid(o_out_ch.valid), .i_out_ready(o_out_ch.ready),
    .i_out_dist(o_out_ch.damped_distance), .i_out_st(o_out_ch.status_out),
    .i_out_flag(o_out_ch.jump_accepted)
);
